### rtl/bswc_pkg.sv
// Package: widths and defaults shared by the bounded-sum window counter.
`default_nettype none
package bswc_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned WINDOW_DEPTH = 1024;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [LEN_W-1:0]   len_t;

endpackage
`default_nettype wire

### rtl/bounded_sum_window_counter_unit.sv
// Top level: bounded-sum window counter over a RAM-backed FIFO window.
`default_nettype none
// Counts, over a stream of unsigned values, the segments ending at each value
// whose sum stays at or below the configured limit, and emits the saturating
// running count once per input transaction. The window of recent values lives
// in one synchronous RAM with registered read data; every removal of the
// oldest entry against the limit is a RAM read followed by a subtract. Each
// item passes through push, pop and finish, repeating pop for each entry
// dropped because the sum exceeds the limit, and holds in finish until
// out_ready_i takes the previous result; a new item is taken only once the
// last one is done. Evicting the oldest entry of a full window happens in
// the push state. Amortized, at most one entry is dropped per item. The RAM
// needs no clearing pass: only entries that have been pushed are ever used.
// The limit register may be written only while the block is idle.
module bounded_sum_window_counter_unit #(
  parameter int unsigned WindowDepth = bswc_pkg::WINDOW_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire bswc_pkg::sum_t   cfg_data_i,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bswc_pkg::value_t value_i,
  input  wire logic             first_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output bswc_pkg::sum_t        segment_total_o,
  output bswc_pkg::len_t        window_length_o,
  output logic                  overflow_o
);
  import bswc_pkg::*;

  localparam int unsigned PtrW = $clog2(WindowDepth);
  localparam int unsigned CntW = $clog2(WindowDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(WindowDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WindowDepth - 1);
  localparam sum_t TotalMax = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_POP_WAIT,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  sum_t            limit_q, limit_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SUM_W:0]  sum_q, sum_d;
  sum_t            total_q, total_d;
  logic            ovf_q, ovf_d;
  value_t          value_q, value_d;
  logic            out_valid_q, out_valid_d;
  sum_t            out_total_q, out_total_d;
  len_t            out_len_q, out_len_d;
  logic            out_ovf_q, out_ovf_d;

  logic            ram_we, ram_re;
  logic [PtrW-1:0] ram_waddr, ram_raddr;
  value_t          ram_rdata;

  logic [SUM_W:0]        popped_sum;
  logic [SUM_W:0]        total_sum;
  logic [CntW+LEN_W-1:0] count_ext;
  logic                  count_is_full;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  bswc_ram #(
    .Width(VALUE_W),
    .Depth(WindowDepth)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(value_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sum after removing the entry just read, clamped at zero
  assign popped_sum = ({{(SUM_W+1-VALUE_W){1'b0}}, ram_rdata} <= sum_q) ?
                      sum_q - {{(SUM_W+1-VALUE_W){1'b0}}, ram_rdata} : '0;
  assign total_sum  = {1'b0, total_q} + {{(SUM_W+1-CntW){1'b0}}, count_q};
  assign count_ext  = {{LEN_W{1'b0}}, count_q};
  assign count_is_full = (count_q == CntFull);

  assign in_ready_o      = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign segment_total_o = out_total_q;
  assign window_length_o = out_len_q;
  assign overflow_o      = out_ovf_q;

  // Sequencer: push, then drop oldest entries until the sum fits
  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    sum_d       = sum_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    value_d     = value_q;
    out_valid_d = out_valid_q;
    out_total_d = out_total_q;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = tail_q;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          value_d = value_i;
          if (first_i) begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
            sum_d   = '0;
            total_d = '0;
            ovf_d   = 1'b0;
          end
          // fetch the oldest entry in case the window is full
          ram_re    = 1'b1;
          ram_raddr = first_i ? '0 : head_q;
          state_d   = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ram_we = 1'b1;
        tail_d = next_ptr(tail_q);
        if (count_is_full) begin
          head_d = next_ptr(head_q);
          ovf_d  = 1'b1;
          sum_d  = popped_sum + {{(SUM_W+1-VALUE_W){1'b0}}, value_q};
        end else begin
          count_d = count_q + 1'b1;
          sum_d   = sum_q + {{(SUM_W+1-VALUE_W){1'b0}}, value_q};
        end
        state_d = ST_POP;
      end
      ST_POP: begin
        if ((count_q != '0) && (sum_q > {1'b0, limit_q})) begin
          ram_re  = 1'b1;
          state_d = ST_POP_WAIT;
        end else begin
          if (count_q == '0) begin
            sum_d  = '0;
            head_d = tail_q;
          end
          state_d = ST_FINISH;
        end
      end
      ST_POP_WAIT: begin
        sum_d   = popped_sum;
        head_d  = next_ptr(head_q);
        count_d = count_q - 1'b1;
        state_d = ST_POP;
      end
      ST_FINISH: begin
        // hold until the previous result has been taken
        if (!out_valid_q || out_ready_i) begin
          if (total_sum[SUM_W]) begin
            total_d     = TotalMax;
            ovf_d       = 1'b1;
            out_total_d = TotalMax;
            out_ovf_d   = 1'b1;
          end else begin
            total_d     = total_sum[SUM_W-1:0];
            out_total_d = total_sum[SUM_W-1:0];
            out_ovf_d   = ovf_q;
          end
          out_len_d   = count_ext[LEN_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      limit_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      limit_q     <= limit_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    out_total_q <= out_total_d;
    out_len_q   <= out_len_d;
    out_ovf_q   <= out_ovf_d;
  end

endmodule
`default_nettype wire

### rtl/bswc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bswc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
